@@ rtl/bvmu_pkg.sv @@
package bvmu_pkg;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;        // capture the request and issue the first memory reads
		logic exec;        // perform writes and latch updates, form the cpu response
		logic finish_pix;  // palette data ready, form the pixel response
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic fetch;       // captured request is a display pixel fetch
	} status_t;

	// 2-bit intensity ladder, index is {colour bits, intensity bits}
	function automatic logic [7:0] level_lookup(input logic [3:0] idx);
		logic [7:0] lvl;
		case (idx)
			4'h0: lvl = 8'h00;
			4'h1: lvl = 8'h12;
			4'h2: lvl = 8'h24;
			4'h3: lvl = 8'h49;
			4'h4: lvl = 8'h12;
			4'h5: lvl = 8'h24;
			4'h6: lvl = 8'h49;
			4'h7: lvl = 8'h92;
			4'h8: lvl = 8'h5b;
			4'h9: lvl = 8'h6d;
			4'ha: lvl = 8'h92;
			4'hb: lvl = 8'hdb;
			4'hc: lvl = 8'h7f;
			4'hd: lvl = 8'h91;
			4'he: lvl = 8'hb6;
			default: lvl = 8'hff;
		endcase
		return lvl;
	endfunction

endpackage

@@ rtl/bvmu_ctrl.sv @@
module bvmu_ctrl import bvmu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    done
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_PIX  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       finish;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	// command decode
	always_comb begin
		cmd.load       = (state_q == ST_IDLE) && start;
		cmd.exec       = (state_q == ST_EXEC);
		cmd.finish_pix = (state_q == ST_PIX);
	end

	assign finish = (cmd.exec && !status.fetch) || cmd.finish_pix;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = status.fetch ? ST_PIX : ST_IDLE;
			end
			ST_PIX: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
		end
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted beat did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result strobe while still busy");

	a_pix_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PIX) |-> ($past(state_q) == ST_EXEC))
		else $error("palette step not preceded by execute step");

endmodule

@@ rtl/bvmu_datapath.sv @@
module bvmu_datapath import bvmu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic [1:0]  req_type,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	input  logic [13:0] row_address,
	input  logic [4:0]  raster_line,
	input  logic [7:0]  pixel_column,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	output logic [7:0]  read_data,
	output logic        handled,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  lamps
);

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_FETCH = 2'd2;
	localparam logic [1:0] REQ_EDGE  = 2'd3;

	localparam logic CFG_MASKED = 1'b0;

	localparam logic [2:0] RG_NONE = 3'd0;
	localparam logic [2:0] RG_VRAM = 3'd1;
	localparam logic [2:0] RG_BANK = 3'd2;
	localparam logic [2:0] RG_PAL  = 3'd3;
	localparam logic [2:0] RG_DATA = 3'd4;
	localparam logic [2:0] RG_MASK = 3'd5;
	localparam logic [2:0] RG_AHI  = 3'd6;
	localparam logic [2:0] RG_ALO  = 3'd7;

	// cpu address decode
	function automatic logic [2:0] decode(input logic [15:0] a, input logic masked);
		logic [2:0] rg;
		rg = RG_NONE;
		if (!a[15]) begin
			rg = RG_VRAM;
		end else begin
			case (a[14:10])
				5'b00010: rg = RG_BANK;
				5'b00100: rg = RG_PAL;
				5'b00101: begin
					case (a[1:0])
						2'd0: rg = RG_DATA;
						2'd1: rg = masked ? RG_MASK : RG_NONE;
						2'd2: rg = RG_AHI;
						default: rg = RG_ALO;
					endcase
				end
				default: rg = RG_NONE;
			endcase
		end
		return rg;
	endfunction

	// scanline reads share the none code, told apart by this flag
	function automatic logic is_scan(input logic [15:0] a);
		return a[15] && (a[14:10] == 5'b00110);
	endfunction

	logic [7:0]  vram_mem [65536];
	logic [7:0]  pal_mem  [1024];

	logic [7:0]  vram_rd_q;
	logic [7:0]  pal_rd_q;

	logic [1:0]  req_q;
	logic [15:0] addr_q;
	logic [7:0]  data_q;
	logic [2:0]  region_q;
	logic        scan_hit_q;
	logic [15:0] vidx_q;
	logic [7:0]  scan_in_q;

	logic        masked_q;
	logic        flip_q;
	logic [7:0]  ahi_q;
	logic [7:0]  alo_q;
	logic [7:0]  mask_q;
	logic [1:0]  bank_q;
	logic [7:0]  lamp_q;
	logic [7:0]  scan_q;

	logic [7:0]  read_data_q;
	logic        handled_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic [7:0]  lamps_q;

	logic [2:0]  region_in;
	logic [15:0] fetch_idx;
	logic [15:0] vidx_in;
	logic [9:0]  pal_raddr;
	logic        is_cpu;
	logic        is_wr;
	logic        vram_we;
	logic [7:0]  vram_wdata;
	logic        pal_we;
	logic [7:0]  lamp_next;
	logic        hit;
	logic [7:0]  rd_value;
	logic [1:0]  inten;

	assign status.fetch = (req_q == REQ_FETCH);

	// read index for the incoming beat
	assign region_in = decode(bus_address, masked_q);
	assign fetch_idx = ({row_address[9:5], raster_line[2:0], 8'h00}
		+ {8'h00, pixel_column}) ^ {16{flip_q}};

	always_comb begin
		if (req_type == REQ_FETCH) begin
			vidx_in = fetch_idx;
		end else if (region_in == RG_VRAM) begin
			vidx_in = {ahi_q[7], bus_address[14:0]};
		end else begin
			vidx_in = {ahi_q, alo_q};
		end
	end

	// palette read address: cpu port on load, pixel lookup on execute
	assign pal_raddr = cmd.exec ? {bank_q, vram_rd_q} : bus_address[9:0];

	// captured request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= req_type;
			addr_q     <= bus_address;
			data_q     <= write_data;
			region_q   <= region_in;
			scan_hit_q <= is_scan(bus_address);
			vidx_q     <= vidx_in;
			scan_in_q  <= {row_address[9:5], raster_line[2:0]};
		end
	end

	// write enables and merged write data
	assign is_cpu     = !req_q[1];
	assign is_wr      = (req_q == REQ_WRITE);
	assign vram_we    = cmd.exec && is_wr && ((region_q == RG_VRAM) || (region_q == RG_DATA));
	assign vram_wdata = masked_q ? ((vram_rd_q & ~mask_q) | (data_q & mask_q)) : data_q;
	assign pal_we     = cmd.exec && is_wr && (region_q == RG_PAL);

	// video ram
	always_ff @(posedge clk) begin
		if (vram_we) begin
			vram_mem[vidx_q] <= vram_wdata;
		end
		if (cmd.load) begin
			vram_rd_q <= vram_mem[vidx_in];
		end
	end

	// palette ram
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[addr_q[9:0]] <= data_q;
		end
		pal_rd_q <= pal_mem[pal_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masked_q <= 1'b0;
			flip_q   <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_MASKED) begin
				masked_q <= cfg_data;
			end else begin
				flip_q <= cfg_data;
			end
		end
	end

	// control latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ahi_q  <= 8'h00;
			alo_q  <= 8'h00;
			mask_q <= 8'hff;
			bank_q <= 2'd0;
			lamp_q <= 8'h00;
			scan_q <= 8'h00;
		end else if (cmd.exec) begin
			if (is_wr && (region_q == RG_AHI)) begin
				ahi_q <= data_q;
			end
			if (is_wr && (region_q == RG_ALO)) begin
				alo_q <= data_q;
			end
			if (is_wr && (region_q == RG_MASK)) begin
				mask_q <= data_q;
			end
			if (is_wr && (region_q == RG_BANK)) begin
				bank_q <= data_q[1:0];
				lamp_q <= lamp_next;
			end
			if (req_q == REQ_EDGE) begin
				scan_q <= scan_in_q;
			end
		end
	end

	assign lamp_next = ~data_q & 8'hfc;

	// cpu response
	assign hit = is_cpu && ((region_q != RG_NONE) || scan_hit_q);

	always_comb begin
		rd_value = 8'h00;
		if (req_q == REQ_READ) begin
			case (region_q)
				RG_VRAM, RG_DATA: rd_value = vram_rd_q;
				RG_PAL:           rd_value = pal_rd_q;
				default:          rd_value = scan_hit_q ? scan_q : 8'h00;
			endcase
		end
	end

	assign inten = pal_rd_q[1:0];

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_data_q <= rd_value;
			handled_q   <= hit;
			red_q       <= 8'h00;
			green_q     <= 8'h00;
			blue_q      <= 8'h00;
			lamps_q     <= (is_wr && (region_q == RG_BANK)) ? lamp_next : lamp_q;
		end else if (cmd.finish_pix) begin
			red_q   <= level_lookup({pal_rd_q[7:6], inten});
			green_q <= level_lookup({pal_rd_q[5:4], inten});
			blue_q  <= level_lookup({pal_rd_q[3:2], inten});
		end
	end

	assign read_data = read_data_q;
	assign handled   = handled_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign lamps     = lamps_q;

endmodule

@@ rtl/bitmap_video_memory_unit_core.sv @@
// channel   direction  handshake              payload
// request   in         start & !busy          req_type, bus_address, write_data,
//                                             row_address, raster_line, pixel_column
// result    out        done (one cycle)       read_data, handled, red, green, blue, lamps
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// cpu and display-enable beats run load and execute steps, pixel fetches add a palette
// step: the fetch chains a video ram read into a palette ram read, each through a
// registered read port. the result strobe rises the cycle after the last step; the next
// beat can start then. arst_n clears the control latches and config; both rams hold
// garbage until written. results cannot be stalled; cfg_ready is always high.
module bitmap_video_memory_unit_core import bvmu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	input  logic [13:0] row_address,
	input  logic [4:0]  raster_line,
	input  logic [7:0]  pixel_column,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        handled,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  lamps,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	// sequencer
	bvmu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// memories, latches and colour expansion
	bvmu_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (req_type),
		.bus_address  (bus_address),
		.write_data   (write_data),
		.row_address  (row_address),
		.raster_line  (raster_line),
		.pixel_column (pixel_column),
		.cfg_we       (cfg_valid & cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.read_data    (read_data),
		.handled      (handled),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.lamps        (lamps)
	);

endmodule

@@ bench/tb_top.sv @@
module tb_top;

	// request kinds as coded on req_type
	typedef enum logic [1:0] {
		REQ_CPU_READ     = 2'd0,
		REQ_CPU_WRITE    = 2'd1,
		REQ_PIXEL_FETCH  = 2'd2,
		REQ_DISPLAY_EDGE = 2'd3
	} req_kind_e;

	// config register indexes
	localparam logic REG_MASKED_WRITES = 1'b0;
	localparam logic REG_FLIP_VIEW     = 1'b1;

	// cpu address pages (address bits 15:10) and port selects inside the port page
	localparam logic [5:0] PAGE_BANK     = 6'h22;
	localparam logic [5:0] PAGE_GAP_LO   = 6'h23;
	localparam logic [5:0] PAGE_PALETTE  = 6'h24;
	localparam logic [5:0] PAGE_PORTS    = 6'h25;
	localparam logic [5:0] PAGE_SCANLINE = 6'h26;
	localparam logic [5:0] PAGE_GAP_HI   = 6'h27;
	localparam logic [1:0] PORT_DATA     = 2'd0;
	localparam logic [1:0] PORT_MASK     = 2'd1;
	localparam logic [1:0] PORT_ADDR_HI  = 2'd2;
	localparam logic [1:0] PORT_ADDR_LO  = 2'd3;

	// intensity ladder, entry n at bits 8n+7:8n
	localparam logic [127:0] LEVEL_STEPS = {
		8'hff, 8'hb6, 8'h91, 8'h7f, 8'hdb, 8'h92, 8'h6d, 8'h5b,
		8'h92, 8'h49, 8'h24, 8'h12, 8'h49, 8'h24, 8'h12, 8'h00
	};

	typedef struct packed {
		req_kind_e   kind;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [13:0] ma;
		logic [4:0]  ra;
		logic [7:0]  col;
	} vid_req_t;

	typedef struct packed {
		logic [7:0] rd;
		logic       hit;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] lamps;
	} vid_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  req_type = '0;
	logic [15:0] bus_address = '0;
	logic [7:0]  write_data = '0;
	logic [13:0] row_address = '0;
	logic [4:0]  raster_line = '0;
	logic [7:0]  pixel_column = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;
	logic        busy;
	logic        done;
	logic [7:0]  read_data;
	logic        handled;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  lamps;
	logic        cfg_ready;

	bitmap_video_memory_unit_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.bus_address  (bus_address),
		.write_data   (write_data),
		.row_address  (row_address),
		.raster_line  (raster_line),
		.pixel_column (pixel_column),
		.done         (done),
		.read_data    (read_data),
		.handled      (handled),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.lamps        (lamps),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// shadow of the video side: memories, latches and mode bits
	logic [7:0]  vram_mem [65536];
	bit          vram_set [65536];
	logic [15:0] vram_list [$];
	logic [7:0]  pal_mem [1024];
	bit          pal_set [1024];
	logic [9:0]  pal_list [$];
	logic [7:0]  addr_hi = 8'h00;
	logic [7:0]  addr_lo = 8'h00;
	logic [7:0]  mask_q = 8'hff;
	logic [1:0]  bank_q = 2'd0;
	logic [7:0]  lamp_q = 8'h00;
	logic [7:0]  scan_q = 8'h00;
	logic        mode_masked = 1'b0;
	logic        mode_flip = 1'b0;

	vid_req_t    pending_reqs [$];
	vid_result_t expected_results [$];
	vid_req_t    cur_req;
	int          burst_left = 1;
	int          gap_left = 0;
	int          issued_count = 0;
	int          mismatch_count = 0;

	// video ram write, blended through the mask on the variant board
	function automatic void store_vram(logic [15:0] idx, logic [7:0] d);
		if (mode_masked)
			vram_mem[idx] = (vram_mem[idx] & ~mask_q) | (d & mask_q);
		else
			vram_mem[idx] = d;
		if (!vram_set[idx]) begin
			vram_set[idx] = 1'b1;
			vram_list.push_back(idx);
		end
	endfunction

	function automatic logic [7:0] channel_level(logic [1:0] c, logic [1:0] inten);
		return LEVEL_STEPS[{c, inten, 3'b000} +: 8];
	endfunction

	// applies one request beat to the shadow state and returns its result beat
	function automatic vid_result_t predict_beat(vid_req_t q);
		vid_result_t res;
		logic [15:0] idx;
		logic [7:0]  colour;
		logic        wr;
		res = '0;
		wr = (q.kind == REQ_CPU_WRITE);
		case (q.kind)
			REQ_CPU_READ, REQ_CPU_WRITE: begin
				if (!q.addr[15]) begin
					idx = {addr_hi[7], q.addr[14:0]};
					res.hit = 1'b1;
					if (wr)
						store_vram(idx, q.data);
					else
						res.rd = vram_mem[idx];
				end else begin
					case (q.addr[15:10])
						PAGE_BANK: begin
							res.hit = 1'b1;
							if (wr) begin
								bank_q = q.data[1:0];
								lamp_q = {~q.data[7:2], 2'b00};
							end
						end
						PAGE_PALETTE: begin
							res.hit = 1'b1;
							if (wr) begin
								pal_mem[q.addr[9:0]] = q.data;
								if (!pal_set[q.addr[9:0]]) begin
									pal_set[q.addr[9:0]] = 1'b1;
									pal_list.push_back(q.addr[9:0]);
								end
							end else begin
								res.rd = pal_mem[q.addr[9:0]];
							end
						end
						PAGE_PORTS: begin
							case (q.addr[1:0])
								PORT_DATA: begin
									res.hit = 1'b1;
									if (wr)
										store_vram({addr_hi, addr_lo}, q.data);
									else
										res.rd = vram_mem[{addr_hi, addr_lo}];
								end
								PORT_MASK: if (mode_masked) begin
									res.hit = 1'b1;
									if (wr)
										mask_q = q.data;
								end
								PORT_ADDR_HI: begin
									res.hit = 1'b1;
									if (wr)
										addr_hi = q.data;
								end
								default: begin
									res.hit = 1'b1;
									if (wr)
										addr_lo = q.data;
								end
							endcase
						end
						PAGE_SCANLINE: begin
							res.hit = 1'b1;
							if (!wr)
								res.rd = scan_q;
						end
						default: ;
					endcase
				end
			end
			REQ_PIXEL_FETCH: begin
				idx = {q.ma[9:5], q.ra[2:0], 8'h00} + {8'h00, q.col};
				if (mode_flip)
					idx = ~idx;
				colour = pal_mem[{bank_q, vram_mem[idx]}];
				res.r = channel_level(colour[7:6], colour[1:0]);
				res.g = channel_level(colour[5:4], colour[1:0]);
				res.b = channel_level(colour[3:2], colour[1:0]);
			end
			default: scan_q = {q.ma[9:5], q.ra[2:0]};
		endcase
		res.lamps = lamp_q;
		return res;
	endfunction

	// request driver: bursts of beats with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				expected_results.push_back(predict_beat(cur_req));
			if (!start || !busy) begin
				if (pending_reqs.size() == 0 || gap_left > 0) begin
					start <= 1'b0;
					if (pending_reqs.size() != 0)
						gap_left--;
				end else begin
					cur_req = pending_reqs.pop_front();
					start <= 1'b1;
					req_type <= cur_req.kind;
					bus_address <= cur_req.addr;
					write_data <= cur_req.data;
					row_address <= cur_req.ma;
					raster_line <= cur_req.ra;
					pixel_column <= cur_req.col;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	// result monitor: every strobed beat against the oldest prediction
	always @(posedge clk) begin
		vid_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result beat with no request outstanding");
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("read_data", want.rd, read_data);
				check_field("handled", {7'd0, want.hit}, {7'd0, handled});
				check_field("red", want.r, red);
				check_field("green", want.g, green);
				check_field("blue", want.b, blue);
				check_field("lamps", want.lamps, lamps);
			end
		end
	end

	// queue one beat and wait until it is taken, so the shadow state is current
	task automatic issue(vid_req_t q);
		pending_reqs.push_back(q);
		issued_count++;
		do @(negedge clk); while (pending_reqs.size() != 0 || start);
	endtask

	function automatic vid_req_t rand_req(req_kind_e k);
		vid_req_t q;
		q.kind = k;
		q.addr = 16'($urandom);
		q.data = 8'($urandom);
		q.ma = 14'($urandom);
		q.ra = 5'($urandom);
		q.col = 8'($urandom);
		return q;
	endfunction

	task automatic cpu(req_kind_e k, logic [15:0] a, logic [7:0] d);
		vid_req_t q;
		q = rand_req(k);
		q.addr = a;
		q.data = d;
		issue(q);
	endtask

	// reach a video ram entry through the direct window or the latched port
	task automatic vram_access(req_kind_e k, logic [15:0] idx, logic [7:0] d);
		if (k == REQ_CPU_WRITE && mode_masked && mask_q != 8'hff && !vram_set[idx])
			cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'($urandom), PORT_MASK}, 8'hff);
		if ($urandom_range(0, 1)) begin
			if (addr_hi[7] != idx[15])
				cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'($urandom), PORT_ADDR_HI},
					{idx[15], 7'($urandom)});
			cpu(k, {1'b0, idx[14:0]}, d);
		end else begin
			if (addr_hi != idx[15:8] || $urandom_range(0, 3) == 0)
				cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'($urandom), PORT_ADDR_HI}, idx[15:8]);
			if (addr_lo != idx[7:0] || $urandom_range(0, 3) == 0)
				cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'($urandom), PORT_ADDR_LO}, idx[7:0]);
			cpu(k, {PAGE_PORTS, 8'($urandom), PORT_DATA}, d);
		end
	endtask

	// display fetch of a written pixel, filling its palette entry first if needed
	task automatic fetch_pixel(logic [15:0] idx);
		vid_req_t    q;
		logic [15:0] seen;
		logic [9:0]  pidx;
		pidx = {bank_q, vram_mem[idx]};
		if (!pal_set[pidx])
			cpu(REQ_CPU_WRITE, {PAGE_PALETTE, pidx}, 8'($urandom));
		seen = mode_flip ? ~idx : idx;
		q = rand_req(REQ_PIXEL_FETCH);
		q.ma[9:5] = seen[15:11];
		q.ra[2:0] = seen[10:8];
		q.col = seen[7:0];
		issue(q);
	endtask

	function automatic logic [15:0] pick_vram();
		return vram_list[$urandom_range(0, vram_list.size() - 1)];
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// config write while the block is idle
	task automatic write_mode(logic reg_idx, logic value);
		wait_drained();
		repeat (4) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (reg_idx == REG_MASKED_WRITES)
			mode_masked = value;
		else
			mode_flip = value;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// random traffic, mostly well-formed access sequences
	task automatic random_phase(int count);
		int          stop_at;
		int          pick;
		req_kind_e   rw;
		vid_req_t    q;
		logic [15:0] a;
		stop_at = issued_count + count;
		while (issued_count < stop_at) begin
			pick = $urandom_range(0, 99);
			rw = $urandom_range(0, 1) ? REQ_CPU_WRITE : REQ_CPU_READ;
			if (pick < 18) begin
				vram_access(REQ_CPU_WRITE, 16'($urandom), 8'($urandom));
			end else if (pick < 26) begin
				vram_access(REQ_CPU_WRITE, pick_vram(), 8'($urandom));
			end else if (pick < 36) begin
				vram_access(REQ_CPU_READ, pick_vram(), 8'($urandom));
			end else if (pick < 44) begin
				cpu(REQ_CPU_WRITE, {PAGE_PALETTE, 10'($urandom)}, 8'($urandom));
			end else if (pick < 48) begin
				cpu(REQ_CPU_READ, {PAGE_PALETTE, pal_list[$urandom_range(0, pal_list.size() - 1)]},
					8'($urandom));
			end else if (pick < 66) begin
				fetch_pixel(pick_vram());
			end else if (pick < 71) begin
				cpu(REQ_CPU_WRITE, {PAGE_BANK, 10'($urandom)}, 8'($urandom));
			end else if (pick < 76) begin
				cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'($urandom), PORT_MASK}, 8'($urandom));
			end else if (pick < 80) begin
				cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'($urandom),
					($urandom_range(0, 1) ? PORT_ADDR_HI : PORT_ADDR_LO)}, 8'($urandom));
			end else if (pick < 88) begin
				// beam row latch, often read back
				q = rand_req(REQ_DISPLAY_EDGE);
				issue(q);
				if ($urandom_range(0, 2) != 0)
					cpu(REQ_CPU_READ, {PAGE_SCANLINE, 10'($urandom)}, 8'($urandom));
			end else if (pick < 94) begin
				// addresses outside the block's map
				case ($urandom_range(0, 3))
					0: a = {5'b10000, 11'($urandom)};
					1: a = {PAGE_GAP_LO, 10'($urandom)};
					2: a = {PAGE_GAP_HI, 10'($urandom)};
					default: a = 16'($urandom_range(16'ha000, 16'hffff));
				endcase
				cpu(rw, a, 8'($urandom));
			end else begin
				// write-only ports read back, read-only scanline written
				case ($urandom_range(0, 2))
					0: cpu(REQ_CPU_READ, {PAGE_BANK, 10'($urandom)}, 8'($urandom));
					1: cpu(REQ_CPU_READ, {PAGE_PORTS, 8'($urandom), 2'($urandom_range(1, 3))},
						8'($urandom));
					default: cpu(REQ_CPU_WRITE, {PAGE_SCANLINE, 10'($urandom)}, 8'($urandom));
				endcase
			end
		end
	endtask

	initial begin
		vid_req_t q;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_mode(REG_MASKED_WRITES, 1'b0);
		write_mode(REG_FLIP_VIEW, 1'b0);

		// bank extremes and lamp pattern, write-only bank read
		cpu(REQ_CPU_WRITE, {PAGE_BANK, 10'h000}, 8'h00);
		cpu(REQ_CPU_WRITE, {PAGE_BANK, 10'h3ff}, 8'hff);
		cpu(REQ_CPU_READ, {PAGE_BANK, 10'h000}, 8'hff);
		// palette ram ends
		cpu(REQ_CPU_WRITE, {PAGE_PALETTE, 10'h000}, 8'hff);
		cpu(REQ_CPU_WRITE, {PAGE_PALETTE, 10'h3ff}, 8'h00);
		cpu(REQ_CPU_READ, {PAGE_PALETTE, 10'h3ff}, 8'hff);
		// address latches, then read back as write-only ports
		cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'h00, PORT_ADDR_HI}, 8'h80);
		cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'hff, PORT_ADDR_LO}, 8'hff);
		cpu(REQ_CPU_READ, {PAGE_PORTS, 8'h00, PORT_ADDR_HI}, 8'h00);
		// direct window ends with the high latch bit set, then the data port
		cpu(REQ_CPU_WRITE, 16'h0000, 8'hff);
		cpu(REQ_CPU_WRITE, 16'h7fff, 8'h00);
		cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'h00, PORT_DATA}, 8'h5a);
		cpu(REQ_CPU_READ, {PAGE_PORTS, 8'hff, PORT_DATA}, 8'h00);
		cpu(REQ_CPU_READ, 16'h7fff, 8'h00);
		// mask port is not decoded without the variant
		cpu(REQ_CPU_WRITE, {PAGE_PORTS, 8'h00, PORT_MASK}, 8'h0f);
		cpu(REQ_CPU_READ, {PAGE_PORTS, 8'hff, PORT_MASK}, 8'h00);
		// foreign addresses
		cpu(REQ_CPU_READ, 16'h8000, 8'h00);
		cpu(REQ_CPU_WRITE, {PAGE_GAP_HI, 10'h3ff}, 8'hff);
		cpu(REQ_CPU_READ, 16'hffff, 8'h00);
		// scanline latch: ignored write, an edge at the all-ones extreme, a read
		cpu(REQ_CPU_WRITE, {PAGE_SCANLINE, 10'h000}, 8'hff);
		q = rand_req(REQ_DISPLAY_EDGE);
		q.ma = '1;
		q.ra = '1;
		issue(q);
		cpu(REQ_CPU_READ, {PAGE_SCANLINE, 10'h3ff}, 8'h00);
		// fetches at the top and bottom of the column range
		fetch_pixel(16'hffff);
		fetch_pixel(16'h8000);

		random_phase(450);
		write_mode(REG_MASKED_WRITES, 1'b1);
		random_phase(450);
		write_mode(REG_FLIP_VIEW, 1'b1);
		random_phase(450);
		write_mode(REG_MASKED_WRITES, 1'b0);
		random_phase(450);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
